// File: hdl/rctc_pkg.sv
// ----------------------------------------------------------------------------
// rctc_pkg
// Shared types and constants for the reference-counted tag cache table.
// ----------------------------------------------------------------------------
package rctc_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_GET     = 2'd0,
        FUNC_ALLOC   = 2'd1,
        FUNC_DUP     = 2'd2,
        FUNC_RELEASE = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_CLAIMED = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_SCAN  = 2'd2,
        S_SLOT  = 2'd3
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic free_now;
        logic is_alloc;
        logic last;
        logic clr_last;
    } t_stat;

endpackage

// File: hdl/rctc_ctrl.sv
// ----------------------------------------------------------------------------
// rctc_ctrl
// Controller: clearing pass, request accept, table scan and slot update.
// ----------------------------------------------------------------------------
module rctc_ctrl import rctc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [FUNC_W-1:0]   i_func,
    input  t_stat               i_stat,
    output t_cmd                o_cmd,
    output logic                o_busy
);

    t_state r_state;
    t_state n_state;
    logic   scan_end;

    assign scan_end = i_stat.hit || (i_stat.is_alloc && i_stat.free_now) || i_stat.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (t_func'(i_func) inside {FUNC_DUP, FUNC_RELEASE}) n_state = S_SLOT;
                    else n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) n_state = S_IDLE;
            end
            S_SLOT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SCAN: begin
                o_cmd.step   = !scan_end;
                o_cmd.finish = scan_end;
            end
            S_SLOT: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/rctc_datapath.sv
// ----------------------------------------------------------------------------
// rctc_datapath
// Entry memory, scan pointer, free-slot tracking and result registers.
// ----------------------------------------------------------------------------
module rctc_datapath import rctc_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [SLOT_W-1:0]   i_slot_in,
    output logic                o_done,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count_out
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ENT_W = 1 + KEY_W + COUNT_BITS;
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

    logic [ENT_W-1:0] mem [ENTRIES];

    t_func               r_func;
    logic [KEY_W-1:0]    r_key;
    logic [SLOT_W-1:0]   r_slot_in;
    logic                r_oor;
    logic [IDX_W-1:0]    r_idx;
    logic [ENT_W-1:0]    r_rdata;
    logic                r_have_free;
    logic [IDX_W-1:0]    r_free_idx;
    logic [IDX_W-1:0]    r_clr_idx;
    logic                r_done;
    logic [SLOT_W-1:0]   r_slot_out;
    t_status             r_status;
    logic [COUNT_W-1:0]  r_count_out;

    logic                  rd_v;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] bumped;
    logic                  hit;
    logic                  free_now;
    logic [IDX_W-1:0]      free_eff;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ENT_W-1:0]      wdata;
    logic [SLOT_W-1:0]     n_slot_out;
    t_status               n_status;
    logic [COUNT_BITS-1:0] n_count;

    assign rd_v     = r_rdata[ENT_W-1];
    assign rd_key   = r_rdata[ENT_W-2 -: KEY_W];
    assign rd_cnt   = r_rdata[COUNT_BITS-1:0];
    assign bumped   = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_ONE;
    assign hit      = rd_v && (rd_key == r_key) && (r_func == FUNC_GET);
    assign free_now = !rd_v;
    assign free_eff = r_have_free ? r_free_idx : r_idx;

    assign o_stat.hit      = hit;
    assign o_stat.free_now = free_now;
    assign o_stat.is_alloc = (r_func == FUNC_ALLOC);
    assign o_stat.last     = (r_idx == LAST_IDX);
    assign o_stat.clr_last = (r_clr_idx == LAST_IDX);

    always_comb begin
        rd_en   = i_cmd.load || i_cmd.step;
        rd_addr = r_idx + IDX_W'(1);
        if (i_cmd.load) begin
            if (t_func'(i_func) inside {FUNC_DUP, FUNC_RELEASE}) rd_addr = IDX_W'(i_slot_in);
            else rd_addr = '0;
        end
    end

    always_comb begin
        we         = 1'b0;
        waddr      = r_idx;
        wdata      = '0;
        n_slot_out = SLOT_W'(r_idx);
        n_status   = ST_OK;
        n_count    = '0;
        if (i_cmd.clear) begin
            we    = 1'b1;
            waddr = r_clr_idx;
        end else if (i_cmd.finish) begin
            case (r_func)
                FUNC_GET, FUNC_ALLOC: begin
                    if (hit) begin
                        we      = 1'b1;
                        wdata   = {1'b1, rd_key, bumped};
                        n_count = bumped;
                    end else if (r_func == FUNC_GET && (r_have_free || free_now)) begin
                        we         = 1'b1;
                        waddr      = free_eff;
                        wdata      = {1'b1, r_key, CNT_ONE};
                        n_slot_out = SLOT_W'(free_eff);
                        n_status   = ST_CLAIMED;
                        n_count    = CNT_ONE;
                    end else if (r_func == FUNC_ALLOC && free_now) begin
                        we       = 1'b1;
                        wdata    = {1'b1, rd_key, CNT_ONE};
                        n_status = ST_CLAIMED;
                        n_count  = CNT_ONE;
                    end else begin
                        n_slot_out = '0;
                        n_status   = ST_FULL;
                    end
                end
                FUNC_DUP, FUNC_RELEASE: begin
                    n_slot_out = r_slot_in;
                    if (r_oor || !rd_v) begin
                        n_status = ST_INVALID;
                    end else if (r_func == FUNC_DUP) begin
                        we      = 1'b1;
                        wdata   = {1'b1, rd_key, bumped};
                        n_count = bumped;
                    end else if (rd_cnt > CNT_ONE) begin
                        we      = 1'b1;
                        wdata   = {1'b1, rd_key, rd_cnt - CNT_ONE};
                        n_count = rd_cnt - CNT_ONE;
                    end else begin
                        we = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_idx <= rd_addr;
        if (i_cmd.load) begin
            r_func    <= t_func'(i_func);
            r_key     <= i_key;
            r_slot_in <= i_slot_in;
            r_oor     <= (32'(i_slot_in) >= 32'(ENTRIES));
        end
        if (i_cmd.step && free_now && !r_have_free) r_free_idx <= r_idx;
        if (i_cmd.finish) begin
            r_slot_out  <= n_slot_out;
            r_status    <= n_status;
            r_count_out <= COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_free <= 1'b0;
            r_clr_idx   <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load) r_have_free <= 1'b0;
            else if (i_cmd.step && free_now) r_have_free <= 1'b1;
            if (i_cmd.clear) r_clr_idx <= r_clr_idx + IDX_W'(1);
        end
    end

    assign o_done      = r_done;
    assign o_slot_out  = r_slot_out;
    assign o_status    = r_status;
    assign o_count_out = r_count_out;

endmodule

// File: hdl/refcounted_tag_cache_table_top.sv
// ----------------------------------------------------------------------------
// refcounted_tag_cache_table_top
// Reference-counted tag cache table: get, alloc, dup and release requests.
// ----------------------------------------------------------------------------
// Get and alloc: after the accept, a scan of the entries through the
// single read port of the entry memory, one entry per cycle; the result is registered.
// Dup and release: accept, then slot read and update; result registered. One request at a time.
// A new request is taken in the result cycle.
// Reset: a clearing pass over every entry zeroes the memory; busy stays high.
module refcounted_tag_cache_table_top import rctc_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [SLOT_W-1:0]   i_slot_in,
    output logic                o_done,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count_out
);

    t_cmd  cmd;
    t_stat stat;

    rctc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rctc_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_slot_in   (i_slot_in),
        .o_done      (o_done),
        .o_slot_out  (o_slot_out),
        .o_status    (o_status),
        .o_count_out (o_count_out)
    );

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one beat");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_slot_out == '0 && o_count_out == '0))
        else $error("full status with nonzero slot or count");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reference-counted tag cache table. Drives get,
// alloc, dup and release beats over the start/busy handshake. A model of the
// table's valid, key and count state predicts every o_done strobe, and each
// strobe is compared field by field. Covers directed corner cases, a full
// table, repeated dup and release on one slot and random traffic under
// several sender idle rates.
// ----------------------------------------------------------------------------
module tb;
    import rctc_pkg::*;

    localparam int ENTRIES   = ENTRIES_DEF;
    localparam int CNT_BITS  = COUNT_BITS_DEF;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
    localparam int GAP_MAX   = 20;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_beat_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   i_func = '0;
    logic [KEY_W-1:0]    i_key = '0;
    logic [SLOT_W-1:0]   i_slot_in = '0;
    logic                o_done;
    logic [SLOT_W-1:0]   o_slot_out;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_count_out;

    logic                tag_live [ENTRIES];
    logic [KEY_W-1:0]    tag_key  [ENTRIES];
    logic [CNT_BITS-1:0] tag_refs [ENTRIES];
    logic [KEY_W-1:0]    hot_keys [8];

    t_beat_res expected_beats[$];
    t_beat_res last_predicted;
    int        idle_pct = 27;
    int        errors = 0;

    refcounted_tag_cache_table_top #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (CNT_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_slot_in   (i_slot_in),
        .o_done      (o_done),
        .o_slot_out  (o_slot_out),
        .o_status    (o_status),
        .o_count_out (o_count_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [CNT_BITS-1:0] sat_inc(logic [CNT_BITS-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

    function automatic int occupied_entries();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tag_live[i])
                n++;
        return n;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_live_slot();
        int live[$];
        for (int i = 0; i < ENTRIES; i++)
            if (tag_live[i])
                live.push_back(i);
        if (live.size() == 0)
            return SLOT_W'($urandom_range(ENTRIES - 1));
        return SLOT_W'(live[$urandom_range(live.size() - 1)]);
    endfunction

    function automatic t_beat_res predict_table_op(t_func f, logic [KEY_W-1:0] k,
                                                   logic [SLOT_W-1:0] s);
        t_beat_res r;
        int        hit;
        int        free_idx;
        hit = -1;
        free_idx = -1;
        r = '{slot: '0, status: ST_OK, count: '0};
        if (f == FUNC_GET || f == FUNC_ALLOC) begin
            if (f == FUNC_GET)
                for (int i = 0; i < ENTRIES; i++)
                    if (hit < 0 && tag_live[i] && tag_key[i] == k)
                        hit = i;
            if (hit >= 0) begin
                tag_refs[hit] = sat_inc(tag_refs[hit]);
                r.slot  = SLOT_W'(hit);
                r.count = COUNT_W'(tag_refs[hit]);
                return r;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (free_idx < 0 && !tag_live[i])
                    free_idx = i;
            if (free_idx < 0) begin
                r.status = ST_FULL;
                return r;
            end
            tag_live[free_idx] = 1'b1;
            tag_refs[free_idx] = CNT_BITS'(1);
            if (f == FUNC_GET)
                tag_key[free_idx] = k;
            r.slot   = SLOT_W'(free_idx);
            r.status = ST_CLAIMED;
            r.count  = COUNT_W'(tag_refs[free_idx]);
            return r;
        end
        r.slot = s;
        if (int'(s) >= ENTRIES || !tag_live[s]) begin
            r.status = ST_INVALID;
            return r;
        end
        if (f == FUNC_DUP) begin
            tag_refs[s] = sat_inc(tag_refs[s]);
        end else if (tag_refs[s] > 1) begin
            tag_refs[s] = tag_refs[s] - 1'b1;
        end else begin
            tag_live[s] = 1'b0;
            tag_key[s]  = '0;
            tag_refs[s] = '0;
        end
        r.count = COUNT_W'(tag_refs[s]);
        return r;
    endfunction

    task automatic send_beat(t_func f, logic [KEY_W-1:0] k, logic [SLOT_W-1:0] s);
        int gap;
        start     <= 1'b1;
        i_func    <= f;
        i_key     <= k;
        i_slot_in <= s;
        do
            @(posedge i_clk);
        while (busy);
        last_predicted = predict_table_op(f, k, s);
        expected_beats.push_back(last_predicted);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            gap = 1;
            while (gap < GAP_MAX && $urandom_range(99) < idle_pct)
                gap++;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic clear_table();
        for (int i = 0; i < ENTRIES; i++)
            while (tag_live[i])
                send_beat(FUNC_RELEASE, $urandom, SLOT_W'(i));
    endtask

    task automatic test_directed_ops();
        send_beat(FUNC_ALLOC,   32'hFFFF_FFFF, 6'd63);
        send_beat(FUNC_GET,     32'h0000_0000, 6'd0);
        send_beat(FUNC_GET,     32'hFFFF_FFFF, 6'd0);
        send_beat(FUNC_GET,     32'hFFFF_FFFF, 6'd63);
        send_beat(FUNC_DUP,     32'h0000_0000, 6'd1);
        send_beat(FUNC_DUP,     32'hFFFF_FFFF, 6'd63);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd63);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd1);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd1);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd1);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd1);
        send_beat(FUNC_DUP,     32'h0000_0000, 6'd1);
        send_beat(FUNC_GET,     32'h8000_0000, 6'd42);
        send_beat(FUNC_GET,     32'h0000_0001, 6'd21);
        send_beat(FUNC_RELEASE, 32'hA5A5_5A5A, 6'd0);
        send_beat(FUNC_RELEASE, 32'hA5A5_5A5A, 6'd0);
        send_beat(FUNC_ALLOC,   32'h5A5A_A5A5, 6'd0);
        send_beat(FUNC_GET,     32'h0000_0001, 6'd0);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd2);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd2);
        send_beat(FUNC_GET,     32'h8000_0000, 6'd63);
    endtask

    task automatic test_table_full();
        while (occupied_entries() < ENTRIES)
            send_beat(FUNC_ALLOC, $urandom, SLOT_W'($urandom_range(ENTRIES - 1)));
        send_beat(FUNC_ALLOC,   $urandom,      6'd0);
        send_beat(FUNC_GET,     32'hC0DE_0001, 6'd5);
        send_beat(FUNC_GET,     32'h0000_0000, 6'd5);
        send_beat(FUNC_RELEASE, 32'h0000_0000, 6'd37);
        send_beat(FUNC_GET,     32'hC0DE_0001, 6'd0);
        send_beat(FUNC_GET,     32'hC0DE_0002, 6'd0);
        clear_table();
    endtask

    task automatic random_beat();
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(99);
        k = ($urandom_range(99) < 70) ? hot_keys[$urandom_range(7)] : $urandom;
        if (occupied_entries() >= ENTRIES - 2 && $urandom_range(1))
            r = 70;
        if (r < 35) begin
            send_beat(FUNC_GET, k, SLOT_W'($urandom_range(ENTRIES - 1)));
        end else if (r < 45) begin
            send_beat(FUNC_ALLOC, k, SLOT_W'($urandom_range(ENTRIES - 1)));
        end else if (r < 60) begin
            send_beat(FUNC_DUP, k, ($urandom_range(99) < 80) ? pick_live_slot()
                                   : SLOT_W'($urandom_range(ENTRIES - 1)));
        end else if (r < 90) begin
            send_beat(FUNC_RELEASE, k, ($urandom_range(99) < 80) ? pick_live_slot()
                                       : SLOT_W'($urandom_range(ENTRIES - 1)));
        end else begin
            // miss followed by a failed load: drop the claimed slot
            send_beat(FUNC_GET, $urandom, SLOT_W'($urandom_range(ENTRIES - 1)));
            if (last_predicted.status == ST_CLAIMED)
                send_beat(FUNC_RELEASE, $urandom, last_predicted.slot);
        end
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++)
            random_beat();
    endtask

    task automatic test_count_updates();
        logic [SLOT_W-1:0] s;
        clear_table();
        send_beat(FUNC_GET, 32'h0BAD_F00D, 6'd9);
        s = last_predicted.slot;
        repeat (40) send_beat(FUNC_DUP, $urandom, s);
        send_beat(FUNC_GET,     32'h0BAD_F00D, 6'd0);
        repeat (45) send_beat(FUNC_RELEASE, 32'h0000_0000, s);
        send_beat(FUNC_DUP,     32'h0000_0000, s);
        send_beat(FUNC_DUP,     32'h0000_0000, s);
    endtask

    always @(posedge i_clk) begin : check_results
        t_beat_res exp_beat;
        if (i_rst_n && o_done) begin
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected result: slot_out %0d status %0d count_out %0d",
                         $time, o_slot_out, o_status, o_count_out);
                errors++;
            end else begin
                exp_beat = expected_beats.pop_front();
                if (o_slot_out !== exp_beat.slot) begin
                    $display("%0t slot_out mismatch: expected %0d actual %0d",
                             $time, exp_beat.slot, o_slot_out);
                    errors++;
                end
                if (o_status !== exp_beat.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, exp_beat.status, o_status);
                    errors++;
                end
                if (o_count_out !== exp_beat.count) begin
                    $display("%0t count_out mismatch: expected %0d actual %0d",
                             $time, exp_beat.count, o_count_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tag_live[i] = 1'b0;
            tag_key[i]  = '0;
            tag_refs[i] = '0;
        end
        hot_keys[0] = '0;
        for (int i = 1; i < 8; i++)
            hot_keys[i] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 27;
        test_directed_ops();
        test_table_full();
        test_random_traffic(220);
        idle_pct = 81;
        test_random_traffic(220);
        idle_pct = 0;
        test_random_traffic(210);
        test_count_updates();

        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_beats.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
